// File: rtl/assert_macros.svh
// Assertion macros shared by the NAT rule table RTL.
// No dependencies; pulled in by the top level, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define NAT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define NAT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/nat1to1_pkg.sv
// Types and codes for the one-to-one NAT rule table.
// No dependencies; imported by the rule cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package nat1to1_pkg;

  localparam int ADDR_W  = 32;
  localparam int CFG_IDX_W = 1;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_FROM_GW = 2'd1,
    CMD_TO_GW   = 2'd2,
    CMD_RSVD    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_CONFLICT = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_NORULE   = 3'd4
  } status_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GATEWAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL   = 1'd1;

  // Lookup token that walks the chain, one cell per cycle
  typedef struct packed {
    logic  vld;
    cmd_t  cmd;
    addr_t a;
    addr_t b;
    logic  o_hit;   // an entry matched on the outer address
    logic  i_hit;   // an entry matched on the inner address
    logic  same;    // both first matches sit in the same entry
    addr_t data;    // partner address captured at the match
  } tok_t;

  // Table update broadcast to every cell
  typedef struct packed {
    logic  append;     // write both fields at the entry indexed by the count
    logic  upd_inner;  // write inner at the entry marked by the outer match
    logic  upd_outer;  // write outer at the entry marked by the inner match
    addr_t a;
    addr_t b;
  } wr_t;

endpackage

`default_nettype wire

// File: rtl/one_to_one_nat_rule_table.sv
// Top level of the one-to-one NAT rule table: command port, config registers,
// and the chain of rule cells. Depends on nat1to1_pkg, nat1to1_cell and assert_macros.svh.
//
// Usage:
//   A command is taken at a rising edge with start high and busy low:
//   in_cmd selects add rule, translate from gateway or translate to gateway,
//   in_first_addr / in_second_addr carry the addresses.
//   The command travels down a row of MAX_RULES rule cells, one cell per
//   cycle, each comparing its stored pair. After the last cell the result is
//   decided and any table update is written in the same edge.
//   Exactly one result follows each command, shown for one cycle with
//   out_valid high: out_status, out_src_addr, out_dst_addr.
//   The result is registered as the token leaves the cell chain; busy falls
//   as the result is registered, so a new command is taken only after the
//   previous command's result has been decided.
//   The receiver cannot stall; results are never held.
//   Configuration: cfg_valid with cfg_index / cfg_data writes gateway_addr
//   (index 0) or local_addr (index 1); cfg_ready is always high.
//   Reset (synchronous, rst_n low) clears both registers and the rule count;
//   rule contents are left as they are and read only below the count.
`timescale 1ns / 1ps
`default_nettype none

module one_to_one_nat_rule_table #(
  parameter int MAX_RULES = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  output logic                                  busy,
  input  wire [1:0]                             in_cmd,
  input  wire [31:0]                            in_first_addr,
  input  wire [31:0]                            in_second_addr,
  output logic                                  out_valid,
  output logic [2:0]                            out_status,
  output logic [31:0]                           out_src_addr,
  output logic [31:0]                           out_dst_addr,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire [nat1to1_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [31:0]                            cfg_data
);
  import nat1to1_pkg::*;

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(MAX_RULES + 1);

  addr_t            gateway_r;
  addr_t            local_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             busy_r;
  logic             out_valid_r;
  status_t          status_r;
  status_t          status_nxt;
  addr_t            src_r;
  addr_t            src_nxt;
  addr_t            dst_r;
  addr_t            dst_nxt;
  logic             accept;
  tok_t             tok [0:MAX_RULES];
  tok_t             last;
  wr_t              wr;

  assign accept    = start && !busy_r;
  assign cfg_ready = 1'b1;

  // Launch the token into the first cell on a command transfer
  always_comb begin
    tok[0]       = '0;
    tok[0].vld   = accept;
    tok[0].cmd   = cmd_t'(in_cmd);
    tok[0].a     = in_first_addr;
    tok[0].b     = in_second_addr;
  end

  // Row of rule cells
  for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
    nat1to1_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .count_i (count_r),
      .tok_i   (tok[g]),
      .wr_i    (wr),
      .tok_o   (tok[g+1])
    );
  end

  assign last = tok[MAX_RULES];

  // Decide the result and the table update when the token leaves the chain
  always_comb begin
    status_nxt = ST_OK;
    src_nxt    = '0;
    dst_nxt    = '0;
    wr         = '0;
    wr.a       = last.a;
    wr.b       = last.b;
    count_nxt  = count_r;
    case (last.cmd)
      CMD_ADD: begin
        if (!last.o_hit && !last.i_hit) begin
          if (count_r == CNT_W'(MAX_RULES)) begin
            status_nxt = ST_FULL;
          end else begin
            wr.append = last.vld;
            if (last.vld) begin
              count_nxt = count_r + CNT_W'(1);
            end
          end
        end else if (last.o_hit && !last.i_hit) begin
          wr.upd_inner = last.vld;
        end else if (last.i_hit && !last.o_hit) begin
          wr.upd_outer = last.vld;
        end else if (!last.same) begin
          status_nxt = ST_CONFLICT;
        end
      end
      CMD_FROM_GW: begin
        if (last.a != gateway_r) begin
          status_nxt = ST_MISMATCH;
        end else if (!last.o_hit) begin
          status_nxt = ST_NORULE;
        end else begin
          src_nxt = local_r;
          dst_nxt = last.data;
        end
      end
      CMD_TO_GW: begin
        if (last.b != local_r) begin
          status_nxt = ST_MISMATCH;
        end else if (!last.i_hit) begin
          status_nxt = ST_NORULE;
        end else begin
          src_nxt = last.data;
          dst_nxt = gateway_r;
        end
      end
      default: begin
        status_nxt = ST_MISMATCH;
      end
    endcase
  end

  // Control: busy, result strobe, rule count, config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      gateway_r   <= '0;
      local_r     <= '0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (last.vld) begin
        busy_r <= 1'b0;
      end
      out_valid_r <= last.vld;
      count_r     <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GATEWAY: gateway_r <= cfg_data;
          REG_LOCAL:   local_r   <= cfg_data;
          default:     ;
        endcase
      end
    end
  end

  // Hold the result fields for the strobe cycle
  always_ff @(posedge clk) begin
    if (last.vld) begin
      status_r <= status_nxt;
      src_r    <= src_nxt;
      dst_r    <= dst_nxt;
    end
  end

  assign busy         = busy_r;
  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_src_addr = src_r;
  assign out_dst_addr = dst_r;

  `NAT_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_RULES), "rule count above capacity")
  `NAT_ASSERT_IMP(a_strobe_after_busy, clk, rst_n, out_valid_r, !busy_r && $past(busy_r), "result without a command in flight")
  `NAT_ASSERT_IMP(a_no_overlap, clk, rst_n, accept, !last.vld, "command taken while another leaves the chain")
  `NAT_ASSERT_IMP(a_count_step, clk, rst_n, $past(rst_n) && count_r != $past(count_r), count_r == $past(count_r) + CNT_W'(1) && $past(wr.append), "rule count moved without an append")
  `NAT_ASSERT_NXT(a_one_result, clk, rst_n, out_valid_r, !out_valid_r, "two results for one command")

endmodule

`default_nettype wire

// File: rtl/nat1to1_cell.sv
// One rule entry of the NAT table: holds a pair, compares the passing token.
// Depends on nat1to1_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nat1to1_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire [CNT_W-1:0]           count_i,
  input  wire nat1to1_pkg::tok_t    tok_i,
  input  wire nat1to1_pkg::wr_t     wr_i,
  output nat1to1_pkg::tok_t         tok_o
);
  import nat1to1_pkg::*;

  addr_t outer_r;
  addr_t inner_r;
  logic  sel_o_r;
  logic  sel_i_r;
  tok_t  tok_r;
  tok_t  tok_nxt;
  logic  occupied;
  logic  look_o;
  logic  look_i;
  addr_t key_o;
  addr_t key_i;

  assign occupied = count_i > CNT_W'(IDX);

  // Compare this entry against the token and claim the first match
  always_comb begin
    key_o  = (tok_i.cmd == CMD_ADD) ? tok_i.a : tok_i.b;
    key_i  = (tok_i.cmd == CMD_ADD) ? tok_i.b : tok_i.a;
    look_o = tok_i.vld && occupied && !tok_i.o_hit &&
             (tok_i.cmd inside {CMD_ADD, CMD_FROM_GW}) && (outer_r == key_o);
    look_i = tok_i.vld && occupied && !tok_i.i_hit &&
             (tok_i.cmd inside {CMD_ADD, CMD_TO_GW}) && (inner_r == key_i);
    tok_nxt       = tok_i;
    tok_nxt.o_hit = tok_i.o_hit | look_o;
    tok_nxt.i_hit = tok_i.i_hit | look_i;
    tok_nxt.same  = tok_i.same | (look_o & look_i);
    if (look_o && tok_i.cmd == CMD_FROM_GW) begin
      tok_nxt.data = inner_r;
    end
    if (look_i && tok_i.cmd == CMD_TO_GW) begin
      tok_nxt.data = outer_r;
    end
  end

  // Advance the token to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.cmd   <= tok_nxt.cmd;
    tok_r.a     <= tok_nxt.a;
    tok_r.b     <= tok_nxt.b;
    tok_r.o_hit <= tok_nxt.o_hit;
    tok_r.i_hit <= tok_nxt.i_hit;
    tok_r.same  <= tok_nxt.same;
    tok_r.data  <= tok_nxt.data;
  end

  // Remember which entry matched, for the update after the pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_o_r <= 1'b0;
      sel_i_r <= 1'b0;
    end else if (tok_i.vld) begin
      sel_o_r <= look_o;
      sel_i_r <= look_i;
    end
  end

  // Write the pair on append or partner update
  always_ff @(posedge clk) begin
    if (wr_i.append && count_i == CNT_W'(IDX)) begin
      outer_r <= wr_i.a;
      inner_r <= wr_i.b;
    end else begin
      if (wr_i.upd_inner && sel_o_r) begin
        inner_r <= wr_i.b;
      end
      if (wr_i.upd_outer && sel_i_r) begin
        outer_r <= wr_i.a;
      end
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire
